### rtl/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg: shared types for the positional insert/delete array
// Command and status codes, and the control word sent down the cell row.
// ----------------------------------------------------------------------------
package pida_pkg;

  // Index width large enough for any supported capacity (up to 8192 cells).
  localparam int unsigned IDX_W = 13;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_READ   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_POP    = 3'd4,
    CMD_REMOVE = 3'd5
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    CK_HOLD = 2'd0,
    CK_LOAD = 2'd1,
    CK_INS  = 2'd2,
    CK_DEL  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   last;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
  } cell_ctl_t;

endpackage

### rtl/pida_if.sv
// ----------------------------------------------------------------------------
// pida_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pida_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  position;
  logic signed [31:0] value_in;

  modport source (output valid, output cmd, output position, output value_in, input ready);
  modport sink   (input valid, input cmd, input position, input value_in, output ready);
endinterface

interface pida_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value_out;
  logic [7:0]  count;
  logic [1:0]  status;

  modport source (output valid, output value_out, output count, output status, input ready);
  modport sink   (input valid, input value_out, input count, input status, output ready);
endinterface

### rtl/positional_insert_delete_array_core.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array_core: bounded list with positional edits
//
//   channel  dir  fields                        beat
//   req      in   cmd, position, value_in       one command
//   rsp      out  value_out, count, status      one result per command
//
// A command is decoded against the element count and takes effect on the
// whole cell row in the cycle it is accepted: one command per cycle.
// Insert and remove shift every affected cell at once toward its neighbor.
// The result sits in an output register; req stalls only while that
// register holds a result that rsp has not taken, and while rst is high.
// Reset clears the count and the output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_core #(
  parameter int unsigned CAPACITY   = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  pida_cmd_if.sink       req,
  pida_rsp_if.source     rsp
);
  import pida_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 8) ? CW : 8;
  localparam int unsigned XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   accept;
  logic                   pos_ok;
  logic [IDX_W-1:0]       pos_idx;
  logic [IDX_W-1:0]       cnt_idx;
  cell_ctl_t              ctl;
  status_e_t              status_next;
  logic [DATA_WIDTH-1:0]  wr_data;
  logic [DATA_WIDTH-1:0]  cell_q  [CAPACITY];
  logic [DATA_WIDTH-1:0]  cell_rd [CAPACITY];
  logic [DATA_WIDTH-1:0]  rd_bus;

  logic                   out_valid;
  logic signed [31:0]     out_value;
  logic [1:0]             out_status;

  assign req.ready = !rst && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign wr_data = DATA_WIDTH'(XW'($unsigned(req.value_in)));
  assign pos_ok  = (req.position != 8'd0) && (PW'(req.position) <= PW'(count));
  assign pos_idx = IDX_W'(req.position) - IDX_W'(1);
  assign cnt_idx = IDX_W'(count);

  always_comb begin
    ctl.op      = CK_HOLD;
    ctl.idx     = '0;
    ctl.last    = '0;
    ctl.rd_en   = 1'b0;
    ctl.rd_idx  = '0;
    status_next = ST_OK;
    count_next  = count;
    case (cmd_e_t'(req.cmd))
      CMD_APPEND: begin
        if (count == CAP_CNT) begin
          status_next = ST_FULL;
        end else begin
          ctl.op     = CK_LOAD;
          ctl.idx    = cnt_idx;
          count_next = count + CW'(1);
        end
      end
      CMD_INSERT: begin
        if (!pos_ok) begin
          status_next = ST_BADPOS;
        end else if (count == CAP_CNT) begin
          status_next = ST_FULL;
        end else begin
          ctl.op     = CK_INS;
          ctl.idx    = pos_idx;
          ctl.last   = cnt_idx;
          count_next = count + CW'(1);
        end
      end
      CMD_READ: begin
        if (!pos_ok) begin
          status_next = ST_BADPOS;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_idx = pos_idx;
        end
      end
      CMD_WRITE: begin
        if (!pos_ok) begin
          status_next = ST_BADPOS;
        end else begin
          ctl.op  = CK_LOAD;
          ctl.idx = pos_idx;
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_idx = cnt_idx - IDX_W'(1);
          count_next = count - CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!pos_ok) begin
          status_next = ST_BADPOS;
        end else begin
          ctl.op     = CK_DEL;
          ctl.idx    = pos_idx;
          ctl.last   = cnt_idx - IDX_W'(1);
          ctl.rd_en  = 1'b1;
          ctl.rd_idx = pos_idx;
          count_next = count - CW'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    // Nothing moves in the row unless a command beat is taken.
    if (!accept) begin
      ctl.op     = CK_HOLD;
      count_next = count;
    end
  end

  // The cell row: each cell sees its neighbors; the ends see zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    pida_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .wr_data (wr_data),
      .left    (left_d),
      .right   (right_d),
      .q       (cell_q[i]),
      .rd      (cell_rd[i])
    );
  end

  // At most one cell drives a nonzero read value, so an OR collects it.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value  <= $signed(32'(XW'(rd_bus)));
      out_status <= status_next;
    end
  end

  logic [CW-1:0] out_count;
  always_ff @(posedge clk) begin
    if (accept) out_count <= count_next;
  end

  assign rsp.valid     = out_valid;
  assign rsp.value_out = out_value;
  assign rsp.count     = 8'(out_count);
  assign rsp.status    = out_status;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ({1'b0, count} == {1'b0, $past(count)}) ||
             ({1'b0, count} == {1'b0, $past(count)} + (CW+1)'(1)) ||
             ({1'b0, count} + (CW+1)'(1) == {1'b0, $past(count)}))
    else $error("element count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_FULL |-> count == CAP_CNT)
    else $error("full status while the list is not full");

  a_stall_holds_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> count == $past(count))
    else $error("count changed while a result was stalled");
`endif

endmodule

### rtl/pida_cell.sv
// ----------------------------------------------------------------------------
// pida_cell: one storage cell of the list
// Holds one element; loads the new value, takes its left neighbor on an
// insert, or takes its right neighbor on a removal.
// ----------------------------------------------------------------------------
module pida_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  pida_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0]  wr_data,
  input  logic [DATA_WIDTH-1:0]  left,
  input  logic [DATA_WIDTH-1:0]  right,
  output logic [DATA_WIDTH-1:0]  q,
  output logic [DATA_WIDTH-1:0]  rd
);
  import pida_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    case (ctl.op)
      CK_LOAD: begin
        if (MY_IDX == ctl.idx) q_next = wr_data;
      end
      CK_INS: begin
        if (MY_IDX == ctl.idx) begin
          q_next = wr_data;
        end else if (MY_IDX > ctl.idx && MY_IDX <= ctl.last) begin
          q_next = left;
        end
      end
      CK_DEL: begin
        if (MY_IDX >= ctl.idx && MY_IDX < ctl.last) q_next = right;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign rd = (ctl.rd_en && MY_IDX == ctl.rd_idx) ? q : '0;

endmodule
